### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion forms for the polyharmonic sine generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PSG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("psg assertion failed");
// condition must never be seen at a clock edge out of reset
`define PSG_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("psg forbidden condition seen");
`else
`define PSG_ASSERT(lbl, clk, rstn, prop)
`define PSG_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### design/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared constants, types and the sine table generator function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

  // default sizing
  localparam int MAX_HARMONICS_DEF   = 8;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HARMONICS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SAMPLES  = 1'd1;

  // register reset values and frame length limits
  localparam logic [3:0] NUM_HARMONICS_RST = 4'd1;
  localparam logic [4:0] LOG2_SAMPLES_RST  = 5'd10;
  localparam logic [4:0] FRAME_BITS_MIN    = 5'd3;
  localparam logic [4:0] FRAME_BITS_MAX    = 5'd16;
  localparam logic [4:0] STEP_POINT        = 5'd24;

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // output range
  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

  // pi/2 in Q30
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_EMIT
  } state_t;

  // quarter-wave entry: Taylor series to x^11 in Q30, rounded to Q1.15
  function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t1;
    logic [63:0]        t2;
    logic [63:0]        t3;
    logic [63:0]        t4;
    logic [63:0]        t5;
    logic signed [63:0] s;
    logic signed [63:0] q;
    x  = (PI_HALF_Q30 * 64'(i)) >> bits;
    x2 = (x * x) >> 30;
    t1 = ((x * x2) >> 30) / 64'd6;
    t2 = ((t1 * x2) >> 30) / 64'd20;
    t3 = ((t2 * x2) >> 30) / 64'd42;
    t4 = ((t3 * x2) >> 30) / 64'd72;
    t5 = ((t4 * x2) >> 30) / 64'd110;
    s  = $signed(x) - $signed(t1) + $signed(t2) - $signed(t3) + $signed(t4) - $signed(t5);
    if (s < 64'sd0) begin
      s = 64'sd0;
    end
    q = (s + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[15:0];
  endfunction

endpackage

### design/polyharmonic_sine_generator.sv
// ----------------------------------------------------------------------------
// polyharmonic_sine_generator
// Multi-tone sine synthesizer: sums up to MAX_HARMONICS table tones per sample.
// ----------------------------------------------------------------------------
// A load request writes one harmonic entry and restarts the frame. A tick
// request is worked through in full before the next request can be taken:
// every harmonic entry is read from the entry and phase memories one per cycle
// and passes through three pipeline stages, with the one shared sine ROM and
// multiplier, into the running sum and then the output register.
// The sample waits in the output register while the next request is taken;
// a following tick holds in its last step until that register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module polyharmonic_sine_generator #(
  parameter int MAX_HARMONICS   = psg_pkg::MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = psg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [2:0]                      in_harmonic_index,
  input  logic signed [15:0]              in_amplitude,
  input  logic [15:0]                     in_phase_offset,
  input  logic [19:0]                     in_frequency,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [23:0]              out_sample,
  output logic [15:0]                     out_sample_index,
  output logic                            out_frame_end,
  output logic                            out_saturated,
  input  logic                            cfg_we,
  input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psg_pkg::*;

  localparam int IDX_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int ACC_W = 33 + IDX_W;
  localparam int SEL_W = 8;
  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(MAX_HARMONICS - 1);
  localparam logic signed [ACC_W:0]   RND_HALF = (ACC_W+1)'(16384);
  localparam logic signed [ACC_W:0]   SAT_HI   = (ACC_W+1)'(SAMPLE_MAX);
  localparam logic signed [ACC_W:0]   SAT_LO   = (ACC_W+1)'(SAMPLE_MIN);

  typedef struct packed {
    logic signed [15:0] amp;
    logic [15:0]        offset;
    logic [31:0]        step;
  } entry_t;

  // configuration registers
  logic [3:0] num_harm_r;
  logic [4:0] log2_samples_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_harm_r     <= NUM_HARMONICS_RST;
      log2_samples_r <= LOG2_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_HARMONICS: num_harm_r     <= cfg_data[3:0];
        CFG_LOG2_SAMPLES:  log2_samples_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame length and step shift
  logic [4:0]  frame_bits;
  logic [4:0]  step_shamt;
  logic [15:0] last_pos;

  always_comb begin
    if (log2_samples_r < FRAME_BITS_MIN) begin
      frame_bits = FRAME_BITS_MIN;
    end else if (log2_samples_r > FRAME_BITS_MAX) begin
      frame_bits = FRAME_BITS_MAX;
    end else begin
      frame_bits = log2_samples_r;
    end
  end

  assign step_shamt = STEP_POINT - frame_bits;
  assign last_pos   = 16'((17'd1 << frame_bits) - 17'd1);

  // request decode
  state_t state_r;
  state_t state_nxt;
  logic   in_acc;
  logic   load_go;
  logic   tick_go;
  logic   emit;

  assign in_acc  = in_valid && in_ready;
  assign load_go = in_acc && (in_req_type == REQ_LOAD);
  assign tick_go = in_acc && (in_req_type == REQ_TICK);

  // entry write on load
  logic [SEL_W-1:0] load_idx_w;
  logic [IDX_W-1:0] ent_waddr;
  logic             ent_we;
  entry_t           ent_wdata;

  assign load_idx_w      = SEL_W'(in_harmonic_index);
  assign ent_waddr       = load_idx_w[IDX_W-1:0];
  assign ent_we          = load_go && (load_idx_w < SEL_W'(MAX_HARMONICS));
  assign ent_wdata.amp    = in_amplitude;
  assign ent_wdata.offset = in_phase_offset;
  assign ent_wdata.step   = 32'(in_frequency) << step_shamt;

  // harmonic issue counter
  logic [IDX_W-1:0] iss_r;
  logic             iss_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r      <= '0;
      iss_busy_r <= 1'b0;
    end else if (tick_go) begin
      iss_r      <= '0;
      iss_busy_r <= 1'b1;
    end else if (iss_busy_r) begin
      if (iss_r == LAST_IDX) begin
        iss_busy_r <= 1'b0;
      end else begin
        iss_r <= iss_r + IDX_W'(1);
      end
    end
  end

  // entry memory
  entry_t                     ent_mem [MAX_HARMONICS];
  entry_t                     ent_rd_r;
  logic [MAX_HARMONICS-1:0]   ent_vld_r;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_r <= ent_mem[iss_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (ent_we) begin
      ent_vld_r[ent_waddr] <= 1'b1;
    end
  end

  // phase memory, fresh entries read as their offset
  logic [31:0]              phase_mem [MAX_HARMONICS];
  logic [31:0]              ph_rd_r;
  logic [MAX_HARMONICS-1:0] fresh_r;
  logic                     restart;
  logic                     ph_we;
  logic [31:0]              ph_next;

  // stage 1: entry and phase read data
  logic             s1_v_r;
  logic             s1_last_r;
  logic [IDX_W-1:0] s1_idx_r;
  entry_t           s1_ent;
  logic [31:0]      s1_phase;

  assign s1_ent   = ent_vld_r[s1_idx_r] ? ent_rd_r : '0;
  assign s1_phase = fresh_r[s1_idx_r] ? {s1_ent.offset, 16'd0} : ph_rd_r;
  assign ph_we    = s1_v_r;
  assign ph_next  = s1_phase + s1_ent.step;

  always_ff @(posedge clk) begin
    if (ph_we) begin
      phase_mem[s1_idx_r] <= ph_next;
    end
    ph_rd_r <= phase_mem[iss_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= '1;
    end else if (restart) begin
      fresh_r <= '1;
    end else if (ph_we) begin
      fresh_r[s1_idx_r] <= 1'b0;
    end
  end

  // sine lookup
  logic signed [15:0] rom_sine;

  psg_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk       (clk),
    .phase_top (s1_phase[31 -: SINE_TABLE_BITS+2]),
    .sine      (rom_sine)
  );

  // stage 2 and 3 registers
  logic               s2_v_r;
  logic               s2_last_r;
  logic               s2_use_r;
  logic signed [15:0] s2_amp_r;
  logic               s3_v_r;
  logic               s3_last_r;
  logic               s3_use_r;
  logic signed [31:0] s3_prod_r;
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= iss_busy_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // datapath: index, amplitude, product and running sum
  always_ff @(posedge clk) begin
    s1_idx_r  <= iss_r;
    s1_last_r <= (iss_r == LAST_IDX);
    s2_last_r <= s1_last_r;
    s2_use_r  <= SEL_W'(s1_idx_r) < SEL_W'(num_harm_r);
    s2_amp_r  <= s1_ent.amp;
    s3_last_r <= s2_last_r;
    s3_use_r  <= s2_use_r;
    s3_prod_r <= s2_use_r ? s2_amp_r * rom_sine : 32'sd0;
    if (tick_go) begin
      acc_r <= '0;
    end else if (s3_v_r) begin
      acc_r <= acc_r + ACC_W'(s3_prod_r);
    end
  end

  // round half up, then clip to 24 bits
  logic signed [ACC_W:0] acc_rnd;
  logic signed [ACC_W:0] acc_val;
  logic                  sat_hi;
  logic                  sat_lo;
  logic signed [23:0]    sample_w;
  logic                  frame_end_w;

  assign acc_rnd     = (ACC_W+1)'(acc_r) + RND_HALF;
  assign acc_val     = acc_rnd >>> 15;
  assign sat_hi      = acc_val > SAT_HI;
  assign sat_lo      = acc_val < SAT_LO;
  assign sample_w    = sat_hi ? SAMPLE_MAX : (sat_lo ? SAMPLE_MIN : acc_val[23:0]);

  // sample counter
  logic [15:0] cnt_r;

  assign frame_end_w = cnt_r >= last_pos;
  assign restart     = load_go || (emit && frame_end_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (restart) begin
      cnt_r <= '0;
    end else if (emit) begin
      cnt_r <= cnt_r + 16'd1;
    end
  end

  // output register
  logic               out_valid_r;
  logic signed [23:0] out_sample_r;
  logic [15:0]        out_index_r;
  logic               out_frame_end_r;
  logic               out_saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample_r    <= sample_w;
      out_index_r     <= cnt_r;
      out_frame_end_r <= frame_end_w;
      out_saturated_r <= sat_hi || sat_lo;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_sample_index = out_index_r;
  assign out_frame_end    = out_frame_end_r;
  assign out_saturated    = out_saturated_r;

  // control state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_req_type == REQ_TICK)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (s3_v_r && s3_last_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // checks
  `PSG_ASSERT(a_last_to_emit, clk, rst_n, s3_v_r && s3_last_r |=> state_r == ST_EMIT)
  `PSG_ASSERT(a_unused_zero, clk, rst_n, s3_v_r && !s3_use_r |-> s3_prod_r == '0)
  `PSG_ASSERT(a_sat_clipped, clk, rst_n, out_valid_r && out_saturated_r |-> out_sample_r == SAMPLE_MAX || out_sample_r == SAMPLE_MIN)
  `PSG_ASSERT_NEVER(a_rw_collide, clk, rst_n, s1_v_r && iss_busy_r && s1_idx_r == iss_r)

endmodule

### design/psg_sine_rom.sv
// ----------------------------------------------------------------------------
// psg_sine_rom
// Quarter-wave sine ROM with quadrant folding and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_sine_rom #(
  parameter int SINE_TABLE_BITS = psg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic [SINE_TABLE_BITS+1:0] phase_top,
  output logic signed [15:0]         sine
);
  import psg_pkg::*;

  localparam int ROM_SIZE = (1 << SINE_TABLE_BITS) + 1;
  localparam int ADDR_W   = SINE_TABLE_BITS + 1;

  typedef logic [15:0] rom_arr_t [ROM_SIZE];

  function automatic rom_arr_t build_rom();
    rom_arr_t r;
    for (int i = 0; i < ROM_SIZE; i++) begin
      r[i] = sine_entry(i, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_arr_t ROM_DATA = build_rom();

  logic [SINE_TABLE_BITS-1:0] frac;
  logic [ADDR_W-1:0]          addr;
  logic [15:0]                rom_q_r;
  logic                       neg_r;

  // odd quadrants run the table backward
  assign frac = phase_top[SINE_TABLE_BITS-1:0];
  assign addr = phase_top[SINE_TABLE_BITS] ?
                (ADDR_W'(1) << SINE_TABLE_BITS) - ADDR_W'(frac) : ADDR_W'(frac);

  // registered table read
  always_ff @(posedge clk) begin
    rom_q_r <= ROM_DATA[addr];
    neg_r   <= phase_top[SINE_TABLE_BITS+1];
  end

  // lower half wave is negated
  assign sine = neg_r ? -$signed(rom_q_r) : $signed(rom_q_r);

endmodule
